### rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, codes and the CRC-16 byte update shared by the frame deframer files.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned M_DATA_W  = 56;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned POS_W     = 17;

    localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY  = 16'hA001;
    localparam logic [15:0]      CRC_LSB   = 16'h0001;
    localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
    localparam logic [POS_W:0]   MIN_FRAME = 18'd11;
    localparam logic [POS_W-1:0] POS_BODY  = 17'd7;

    // Byte positions of the header fields
    localparam logic [POS_W-1:0] POS_START1 = 17'd0;
    localparam logic [POS_W-1:0] POS_START2 = 17'd1;
    localparam logic [POS_W-1:0] POS_VER    = 17'd2;
    localparam logic [POS_W-1:0] POS_CMD    = 17'd3;
    localparam logic [POS_W-1:0] POS_SEQ    = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd5;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd6;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_BOUNDARY = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_CRC_MISMATCH = 3'd4
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_START_FIRST  = 2'd0,
        REG_START_SECOND = 2'd1,
        REG_END_FIRST    = 2'd2,
        REG_END_SECOND   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload;
        t_status     status;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [7:0]  seq_no;
        logic [15:0] length;
        logic        last;
    } t_result;

    // CRC-16/MODBUS, reflected, one byte, unrolled over its eight bits
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_LSB) != 16'h0000) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/crc16_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// Byte-stream frame decoder: passes payload bytes, checks CRC-16/MODBUS and
// framing, and closes each frame with one status beat.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                          | tuser       | tlast
//  s_axis    | in  | frame_byte                     | -           | frame_end
//  m_axis    | out | payload_byte, status_code,     | result_kind | last_of_run
//            |     | frame_version, frame_command,  |             |
//            |     | frame_sequence, payload_length |             |
//  apb       | in  | start/end byte registers at 0x0, 0x4, 0x8, 0xC
//
//  One input byte is taken per cycle; the frame state and the CRC update sit
//  in one register stage, so a result is written to the queue in the cycle
//  the byte is taken. A final byte that is also a payload byte yields two
//  beats; a four-entry result queue absorbs the extra beat, and s_axis stalls
//  while fewer than two entries are free. Results leave the queue at one beat
//  per cycle while m_axis is ready. Reset is synchronous: it clears the frame
//  state, the queue and the configuration registers.
// ----------------------------------------------------------------------------
module crc16_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // s_axis
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // [7:0] frame_byte
    input  logic                           i_s_axis_tlast,
    // m_axis
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] payload_byte, [10:8] status_code, [18:11] frame_version,
    // [26:19] frame_command, [34:27] frame_sequence, [50:35] payload_length,
    // [55:51] zero
    output logic [cfd_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    output logic                           o_m_axis_tuser,   // [0] result_kind
    output logic                           o_m_axis_tlast,
    // apb
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cfd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cfd_pkg::*;

    // configuration
    logic [7:0] r_start1, r_start2, r_end1, r_end2;
    t_cfg_reg   cfg_sel;
    logic       cfg_wr;

    // frame state
    logic [POS_W-1:0] r_pos,      n_pos;
    logic [15:0]      r_crc,      n_crc;
    logic             r_start_ok, n_start_ok;
    logic [7:0]       r_ver,      n_ver;
    logic [7:0]       r_cmd,      n_cmd;
    logic [7:0]       r_seq,      n_seq;
    logic [15:0]      r_len,      n_len;
    logic [31:0]      r_recent,   n_recent;

    // result queue
    t_result     r_mem [4];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count;
    logic        in_acc, out_acc;
    t_result     res0, res1;
    logic [1:0]  push_n;

    // per-byte work
    logic [7:0]       b;
    logic [POS_W:0]   body_end;
    logic [POS_W:0]   count;
    logic             in_body, in_crc, end_ok;
    logic [15:0]      rx_crc;
    t_status          status;
    t_result          pay_res, st_res;

    assign pready  = 1'b1;
    assign cfg_sel = t_cfg_reg'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_sel)
            REG_START_FIRST:  prdata = {24'h0, r_start1};
            REG_START_SECOND: prdata = {24'h0, r_start2};
            REG_END_FIRST:    prdata = {24'h0, r_end1};
            REG_END_SECOND:   prdata = {24'h0, r_end2};
            default:          prdata = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start1 <= 8'h00;
            r_start2 <= 8'h00;
            r_end1   <= 8'h00;
            r_end2   <= 8'h00;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_START_FIRST:  r_start1 <= pwdata[7:0];
                REG_START_SECOND: r_start2 <= pwdata[7:0];
                REG_END_FIRST:    r_end1   <= pwdata[7:0];
                REG_END_SECOND:   r_end2   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_count <= 3'd2);
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != 3'd0);
    assign out_acc         = o_m_axis_tvalid & i_m_axis_tready;

    assign b        = i_s_axis_tdata;
    assign body_end = {1'b0, POS_BODY} + {2'b00, r_len};
    assign in_crc   = (r_pos >= POS_VER)  && ({1'b0, r_pos} < body_end);
    assign in_body  = (r_pos >= POS_BODY) && ({1'b0, r_pos} < body_end);

    always_comb begin
        n_start_ok = r_start_ok;
        n_ver      = r_ver;
        n_cmd      = r_cmd;
        n_seq      = r_seq;
        n_len      = r_len;
        n_crc      = r_crc;
        n_pos      = r_pos;

        if (r_pos == POS_START1 && b != r_start1) n_start_ok = 1'b0;
        if (r_pos == POS_START2 && b != r_start2) n_start_ok = 1'b0;
        if (r_pos == POS_VER)    n_ver = b;
        if (r_pos == POS_CMD)    n_cmd = b;
        if (r_pos == POS_SEQ)    n_seq = b;
        if (r_pos == POS_LEN_LO) n_len = {r_len[15:8], b};
        if (r_pos == POS_LEN_HI) n_len = {b, r_len[7:0]};
        if (in_crc)              n_crc = crc_byte(r_crc, b);
        n_recent = {r_recent[23:0], b};
        // hold the count at its ceiling; an over-long frame fails the length check
        if (r_pos < POS_MAX)     n_pos = r_pos + 17'd1;
    end

    assign count  = {1'b0, r_pos} + 18'd1;
    assign rx_crc = {n_recent[23:16], n_recent[31:24]};
    assign end_ok = (n_recent[15:8] == r_end1) && (n_recent[7:0] == r_end2);

    always_comb begin
        if (count < MIN_FRAME) begin
            status = ST_TOO_SHORT;
        end else if (!n_start_ok || !end_ok) begin
            status = ST_BAD_BOUNDARY;
        end else if (count != MIN_FRAME + {2'b00, n_len}) begin
            status = ST_LEN_MISMATCH;
        end else if (n_crc != rx_crc) begin
            status = ST_CRC_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        pay_res         = '0;
        pay_res.kind    = KIND_PAYLOAD;
        pay_res.payload = b;

        st_res          = '0;
        st_res.kind     = KIND_STATUS;
        st_res.status   = status;
        st_res.version  = n_ver;
        st_res.command  = n_cmd;
        st_res.seq_no   = n_seq;
        st_res.length   = n_len;
        st_res.last     = 1'b1;

        res0   = st_res;
        res1   = st_res;
        push_n = 2'd0;
        if (in_body) begin
            res0   = pay_res;
            push_n = i_s_axis_tlast ? 2'd2 : 2'd1;
        end else if (i_s_axis_tlast) begin
            push_n = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
            r_start_ok <= 1'b1;
            r_ver      <= 8'h00;
            r_cmd      <= 8'h00;
            r_seq      <= 8'h00;
            r_len      <= 16'h0000;
            r_recent   <= 32'h0;
        end else if (in_acc) begin
            if (i_s_axis_tlast) begin
                // drop all frame state after the final byte
                r_pos      <= '0;
                r_crc      <= CRC_INIT;
                r_start_ok <= 1'b1;
                r_ver      <= 8'h00;
                r_cmd      <= 8'h00;
                r_seq      <= 8'h00;
                r_len      <= 16'h0000;
                r_recent   <= 32'h0;
            end else begin
                r_pos      <= n_pos;
                r_crc      <= n_crc;
                r_start_ok <= n_start_ok;
                r_ver      <= n_ver;
                r_cmd      <= n_cmd;
                r_seq      <= n_seq;
                r_len      <= n_len;
                r_recent   <= n_recent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= res0;
        end
        if (in_acc && push_n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + push_n;
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (in_acc ? {1'b0, push_n} : 3'd0) - {2'b00, out_acc};
        end
    end

    t_result head;
    assign head           = r_mem[r_rd_ptr];
    assign o_m_axis_tdata = {5'b00000, head.length, head.seq_no, head.command,
                             head.version, head.status, head.payload};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

### rtl/core/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cfd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    input  logic [cfd_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    input  logic                         o_m_axis_tuser,
    input  logic                         o_m_axis_tlast
);
    import cfd_pkg::*;

    // a status beat always closes the run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_STATUS) |->
            (o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'h00))
        else $error("status beat without tlast or with payload data");

    // a payload beat carries the byte alone
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_PAYLOAD) |->
            (!o_m_axis_tlast && o_m_axis_tdata[55:8] == 48'h0))
        else $error("payload beat with status fields set");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[10:8] <= ST_CRC_MISMATCH))
        else $error("status code out of range");

    // hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled result beat changed");

endmodule

bind crc16_frame_deframer cfd_checker u_cfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
